/* src/hsh_pkg.sv */
// Shared types, constants and tables for the Hermite spline heading stepper.
`default_nettype none
package hsh_pkg;

    localparam int STEPS        = 100;
    localparam int CORDIC_ITERS = 16;
    localparam int K_W          = $clog2(STEPS + 1);
    localparam int UREM_W       = $clog2(2 * STEPS);
    localparam int U_W          = 17;
    localparam logic [U_W-1:0]    U_STEP = U_W'(65536 / STEPS);
    localparam logic [UREM_W-1:0] U_REM  = UREM_W'(65536 % STEPS);
    localparam logic [UREM_W-1:0] U_WRAP = UREM_W'(STEPS);
    localparam logic [K_W-1:0]    K_LAST = K_W'(STEPS);

    localparam int SQRT_ITERS = 23;
    localparam int DIV_SHIFT  = 16 + $clog2(STEPS);
    localparam logic [16:0] DIV_RECIP = 17'((2 ** DIV_SHIFT + STEPS - 1) / STEPS);

    localparam int ITER_W  = 5;
    localparam int MUL_A_W = 26;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = 44;
    localparam int ACC_W   = 46;
    localparam int POS_W   = 32;
    localparam int V_W     = 36;
    localparam int Z_W     = 27;
    localparam int SQ_W    = 46;
    localparam logic signed [V_W-1:0] CORDIC_GAIN_INV = V_W'(39797);
    localparam logic signed [Z_W-1:0] HALF_TURN_Q16   = Z_W'(180 * 65536);

    localparam logic [1:0] CFG_GOAL_X       = 2'd0;
    localparam logic [1:0] CFG_GOAL_Y       = 2'd1;
    localparam logic [1:0] CFG_GOAL_HEADING = 2'd2;

    typedef enum logic [4:0] {
        OP_NOP, OP_SQX, OP_SQY, OP_SQS, OP_RTI, OP_RT, OP_DVI,
        OP_CRI, OP_CR, OP_TX, OP_TY, OP_TW, OP_UU, OP_U2, OP_U3M, OP_U3,
        OP_M1, OP_M2, OP_M3, OP_M4, OP_PW, OP_VI, OP_VR, OP_FIN
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_SQX, S_SQY, S_SQS, S_RTI, S_RT, S_DVI,
        S_CRI, S_CR, S_TX, S_TY, S_TW, S_UU, S_U2, S_U3M, S_U3,
        S_M1, S_M2, S_M3, S_M4, S_PW, S_VI, S_VR, S_FIN
    } state_t;

    typedef struct packed {
        op_t               op;
        logic [ITER_W-1:0] iter;
        logic              sel;
        logic              load;
    } cmd_t;

    typedef struct packed {
        logic k_zero;
        logic out_busy;
    } status_t;

    function automatic logic signed [Z_W-1:0] atan_deg(input logic [ITER_W-1:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:  v = Z_W'(2949120);
            5'd1:  v = Z_W'(1740967);
            5'd2:  v = Z_W'(919879);
            5'd3:  v = Z_W'(466945);
            5'd4:  v = Z_W'(234379);
            5'd5:  v = Z_W'(117302);
            5'd6:  v = Z_W'(58666);
            5'd7:  v = Z_W'(29335);
            5'd8:  v = Z_W'(14668);
            5'd9:  v = Z_W'(7334);
            5'd10: v = Z_W'(3667);
            5'd11: v = Z_W'(1833);
            5'd12: v = Z_W'(917);
            5'd13: v = Z_W'(458);
            5'd14: v = Z_W'(229);
            5'd15: v = Z_W'(115);
            5'd16: v = Z_W'(57);
            5'd17: v = Z_W'(29);
            5'd18: v = Z_W'(14);
            5'd19: v = Z_W'(7);
            5'd20: v = Z_W'(4);
            5'd21: v = Z_W'(2);
            5'd22: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* src/hsh_ctrl.sv */
// Sequencer that steps the shared datapath through one transaction.
`default_nettype none
module hsh_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire hsh_pkg::status_t status,
    output hsh_pkg::cmd_t        cmd
);

    hsh_pkg::state_t state_reg, state_next;
    logic [hsh_pkg::ITER_W-1:0] iter_reg, iter_next;
    logic sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hsh_pkg::S_IDLE;
            iter_reg  <= '0;
            sel_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
            sel_reg   <= sel_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        iter_next  = iter_reg + 1'b1;
        sel_next   = sel_reg;
        s_ready    = 1'b0;
        cmd.op     = hsh_pkg::OP_NOP;
        cmd.iter   = iter_reg;
        cmd.sel    = sel_reg;
        cmd.load   = 1'b0;
        case (state_reg)
            hsh_pkg::S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = status.k_zero ? hsh_pkg::S_SQX : hsh_pkg::S_UU;
                end
            end
            hsh_pkg::S_SQX: begin
                cmd.op = hsh_pkg::OP_SQX;
                state_next = hsh_pkg::S_SQY;
            end
            hsh_pkg::S_SQY: begin
                cmd.op = hsh_pkg::OP_SQY;
                state_next = hsh_pkg::S_SQS;
            end
            hsh_pkg::S_SQS: begin
                cmd.op = hsh_pkg::OP_SQS;
                state_next = hsh_pkg::S_RTI;
            end
            hsh_pkg::S_RTI: begin
                cmd.op = hsh_pkg::OP_RTI;
                iter_next = '0;
                state_next = hsh_pkg::S_RT;
            end
            hsh_pkg::S_RT: begin
                cmd.op = hsh_pkg::OP_RT;
                if (iter_reg == hsh_pkg::ITER_W'(hsh_pkg::SQRT_ITERS - 1)) begin
                    state_next = hsh_pkg::S_DVI;
                end
            end
            hsh_pkg::S_DVI: begin
                cmd.op = hsh_pkg::OP_DVI;
                sel_next = 1'b0;
                state_next = hsh_pkg::S_CRI;
            end
            hsh_pkg::S_CRI: begin
                cmd.op = hsh_pkg::OP_CRI;
                iter_next = '0;
                state_next = hsh_pkg::S_CR;
            end
            hsh_pkg::S_CR: begin
                cmd.op = hsh_pkg::OP_CR;
                if (iter_reg == hsh_pkg::ITER_W'(hsh_pkg::CORDIC_ITERS - 1)) begin
                    state_next = hsh_pkg::S_TX;
                end
            end
            hsh_pkg::S_TX: begin
                cmd.op = hsh_pkg::OP_TX;
                state_next = hsh_pkg::S_TY;
            end
            hsh_pkg::S_TY: begin
                cmd.op = hsh_pkg::OP_TY;
                state_next = hsh_pkg::S_TW;
            end
            hsh_pkg::S_TW: begin
                cmd.op = hsh_pkg::OP_TW;
                if (sel_reg) begin
                    state_next = hsh_pkg::S_UU;
                end else begin
                    sel_next = 1'b1;
                    state_next = hsh_pkg::S_CRI;
                end
            end
            hsh_pkg::S_UU: begin
                cmd.op = hsh_pkg::OP_UU;
                state_next = hsh_pkg::S_U2;
            end
            hsh_pkg::S_U2: begin
                cmd.op = hsh_pkg::OP_U2;
                state_next = hsh_pkg::S_U3M;
            end
            hsh_pkg::S_U3M: begin
                cmd.op = hsh_pkg::OP_U3M;
                state_next = hsh_pkg::S_U3;
            end
            hsh_pkg::S_U3: begin
                cmd.op = hsh_pkg::OP_U3;
                sel_next = 1'b0;
                state_next = hsh_pkg::S_M1;
            end
            hsh_pkg::S_M1: begin
                cmd.op = hsh_pkg::OP_M1;
                state_next = hsh_pkg::S_M2;
            end
            hsh_pkg::S_M2: begin
                cmd.op = hsh_pkg::OP_M2;
                state_next = hsh_pkg::S_M3;
            end
            hsh_pkg::S_M3: begin
                cmd.op = hsh_pkg::OP_M3;
                state_next = hsh_pkg::S_M4;
            end
            hsh_pkg::S_M4: begin
                cmd.op = hsh_pkg::OP_M4;
                state_next = hsh_pkg::S_PW;
            end
            hsh_pkg::S_PW: begin
                cmd.op = hsh_pkg::OP_PW;
                if (sel_reg) begin
                    state_next = hsh_pkg::S_VI;
                end else begin
                    sel_next = 1'b1;
                    state_next = hsh_pkg::S_M1;
                end
            end
            hsh_pkg::S_VI: begin
                cmd.op = hsh_pkg::OP_VI;
                iter_next = '0;
                state_next = hsh_pkg::S_VR;
            end
            hsh_pkg::S_VR: begin
                cmd.op = hsh_pkg::OP_VR;
                if (iter_reg == hsh_pkg::ITER_W'(hsh_pkg::CORDIC_ITERS - 1)) begin
                    state_next = hsh_pkg::S_FIN;
                end
            end
            hsh_pkg::S_FIN: begin
                if (!status.out_busy) begin
                    cmd.op = hsh_pkg::OP_FIN;
                    state_next = hsh_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = hsh_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* src/hsh_dp.sv */
// Datapath: config registers, shared multiplier, square root, divider, CORDIC, output register.
`default_nettype none
module hsh_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic [1:0]          cfg_addr,
    input  wire logic [14:0]         cfg_wdata,
    input  wire logic signed [8:0]   s_current_heading,
    input  wire hsh_pkg::cmd_t       cmd,
    output hsh_pkg::status_t         status,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [7:0]               m_step_distance,
    output logic signed [9:0]        m_turn_angle,
    output logic                     m_last_step
);

    localparam int AW = hsh_pkg::MUL_A_W;
    localparam int BW = hsh_pkg::MUL_B_W;
    localparam int VW = hsh_pkg::V_W;
    localparam int ZW = hsh_pkg::Z_W;

    logic signed [14:0] goal_x_reg, goal_y_reg;
    logic signed [8:0]  goal_heading_reg, head_reg;
    logic [hsh_pkg::K_W-1:0]    k_reg;
    logic [hsh_pkg::U_W-1:0]    u_reg, u2_reg, u3_reg;
    logic [hsh_pkg::UREM_W-1:0] urem_reg;
    logic signed [hsh_pkg::PROD_W-1:0] prod_reg;
    logic signed [hsh_pkg::ACC_W-1:0]  acc_reg;
    logic [hsh_pkg::SQ_W-1:0] sn_reg, sr_reg, sbit_reg;
    logic [23:0] pl_reg, dq_reg;
    logic signed [AW-1:0] tsx_reg, tsy_reg, tex_reg, tey_reg;
    logic signed [hsh_pkg::POS_W-1:0] sx_reg, sy_reg, prev_x_reg, prev_y_reg;
    logic signed [VW-1:0] cx_reg, cy_reg;
    logic signed [ZW-1:0] cz_reg;
    logic c_neg_reg, zero_vec_reg;
    logic m_valid_reg, m_last_reg;
    logic [7:0] m_dist_reg;
    logic signed [9:0] m_turn_reg;

    logic signed [AW-1:0] mul_a;
    logic signed [BW-1:0] mul_b;
    logic signed [19:0] u_s, u2_s, u3_s, h2, h3, h4;
    logic signed [VW-1:0] trig_c, trig_s, x_sh, y_sh, x_step, y_step;
    logic signed [ZW-1:0] at, z_step;
    logic ccw;
    logic signed [10:0] ang_raw, ang_red, ang_q;
    logic ang_neg;
    logic [hsh_pkg::SQ_W:0] sq_try;
    logic [32:0] div_prod;
    logic signed [hsh_pkg::POS_W:0] dx, dy;
    logic signed [ZW-1:0] z_abs;
    logic [ZW-1:0] z_rnd;
    logic [8:0] phi_mag;
    logic signed [9:0] phi;
    logic [hsh_pkg::UREM_W-1:0] urem_sum;

    assign status.k_zero   = (k_reg == '0);
    assign status.out_busy = m_valid_reg && !m_ready;
    assign m_valid         = m_valid_reg;
    assign m_step_distance = m_dist_reg;
    assign m_turn_angle    = m_turn_reg;
    assign m_last_step     = m_last_reg;

    always_comb begin
        u_s  = $signed({3'b000, u_reg});
        u2_s = $signed({3'b000, u2_reg});
        u3_s = $signed({3'b000, u3_reg});
        h2 = (u2_s <<< 1) + u2_s - (u3_s <<< 1);
        h3 = u3_s - (u2_s <<< 1) + u_s;
        h4 = u3_s - u2_s;
        trig_c = c_neg_reg ? -cx_reg : cx_reg;
        trig_s = c_neg_reg ? -cy_reg : cy_reg;
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            hsh_pkg::OP_SQX: begin
                mul_a = AW'(goal_x_reg);
                mul_b = BW'(goal_x_reg);
            end
            hsh_pkg::OP_SQY: begin
                mul_a = AW'(goal_y_reg);
                mul_b = BW'(goal_y_reg);
            end
            hsh_pkg::OP_TX: begin
                mul_a = AW'($signed({1'b0, pl_reg}));
                mul_b = trig_c[BW-1:0];
            end
            hsh_pkg::OP_TY: begin
                mul_a = AW'($signed({1'b0, pl_reg}));
                mul_b = trig_s[BW-1:0];
            end
            hsh_pkg::OP_UU: begin
                mul_a = AW'(u_s);
                mul_b = u_s[BW-1:0];
            end
            hsh_pkg::OP_U3M: begin
                mul_a = AW'(u2_s);
                mul_b = u_s[BW-1:0];
            end
            hsh_pkg::OP_M1: begin
                mul_a = cmd.sel ? (AW'(goal_y_reg) <<< 8) : (AW'(goal_x_reg) <<< 8);
                mul_b = h2[BW-1:0];
            end
            hsh_pkg::OP_M2: begin
                mul_a = cmd.sel ? tsy_reg : tsx_reg;
                mul_b = h3[BW-1:0];
            end
            hsh_pkg::OP_M3: begin
                mul_a = cmd.sel ? tey_reg : tex_reg;
                mul_b = h4[BW-1:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared CORDIC stage: rotation steers by z, vectoring by y
    always_comb begin
        x_sh = cx_reg >>> cmd.iter;
        y_sh = cy_reg >>> cmd.iter;
        at   = hsh_pkg::atan_deg(cmd.iter);
        ccw  = (cmd.op == hsh_pkg::OP_CR) ? !cz_reg[ZW-1] : cy_reg[VW-1];
        x_step = ccw ? cx_reg - y_sh : cx_reg + y_sh;
        y_step = ccw ? cy_reg + x_sh : cy_reg - x_sh;
        z_step = ccw ? cz_reg - at : cz_reg + at;
    end

    always_comb begin
        ang_raw = 11'(cmd.sel ? goal_heading_reg : head_reg);
        if (ang_raw > 11'sd180) begin
            ang_red = ang_raw - 11'sd360;
        end else if (ang_raw < -11'sd180) begin
            ang_red = ang_raw + 11'sd360;
        end else begin
            ang_red = ang_raw;
        end
        ang_neg = 1'b0;
        ang_q   = ang_red;
        if (ang_red > 11'sd90) begin
            ang_q   = ang_red - 11'sd180;
            ang_neg = 1'b1;
        end else if (ang_red < -11'sd90) begin
            ang_q   = ang_red + 11'sd180;
            ang_neg = 1'b1;
        end
    end

    always_comb begin
        sq_try = {1'b0, sr_reg} + {1'b0, sbit_reg};
        div_prod = sr_reg[23:8] * hsh_pkg::DIV_RECIP;
        dx = (hsh_pkg::POS_W+1)'(sx_reg) - (hsh_pkg::POS_W+1)'(prev_x_reg);
        dy = (hsh_pkg::POS_W+1)'(sy_reg) - (hsh_pkg::POS_W+1)'(prev_y_reg);
        z_abs = cz_reg[ZW-1] ? -cz_reg : cz_reg;
        z_rnd = (ZW'(z_abs) + ZW'(32768)) >> 16;
        phi_mag = (z_rnd > ZW'(180)) ? 9'd180 : z_rnd[8:0];
        if (zero_vec_reg) begin
            phi = '0;
        end else begin
            phi = cz_reg[ZW-1] ? -$signed({1'b0, phi_mag}) : $signed({1'b0, phi_mag});
        end
        urem_sum = urem_reg + hsh_pkg::U_REM;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goal_x_reg       <= '0;
            goal_y_reg       <= '0;
            goal_heading_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                hsh_pkg::CFG_GOAL_X:       goal_x_reg <= $signed(cfg_wdata);
                hsh_pkg::CFG_GOAL_Y:       goal_y_reg <= $signed(cfg_wdata);
                hsh_pkg::CFG_GOAL_HEADING: goal_heading_reg <= $signed(cfg_wdata[8:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg       <= '0;
            u_reg       <= '0;
            urem_reg    <= '0;
            m_valid_reg <= 1'b0;
            pl_reg      <= '0;
            dq_reg      <= '0;
            tsx_reg     <= '0;
            tsy_reg     <= '0;
            tex_reg     <= '0;
            tey_reg     <= '0;
            prev_x_reg  <= '0;
            prev_y_reg  <= '0;
        end else begin
            if (m_valid_reg && m_ready && (cmd.op != hsh_pkg::OP_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            case (cmd.op)
                hsh_pkg::OP_SQX: begin
                    prev_x_reg <= '0;
                    prev_y_reg <= '0;
                end
                hsh_pkg::OP_DVI: begin
                    pl_reg <= sr_reg[23:0];
                    dq_reg <= 24'(div_prod >> hsh_pkg::DIV_SHIFT);
                end
                hsh_pkg::OP_TY: begin
                    if (cmd.sel) tex_reg <= prod_reg[AW+15:16];
                    else         tsx_reg <= prod_reg[AW+15:16];
                end
                hsh_pkg::OP_TW: begin
                    if (cmd.sel) tey_reg <= prod_reg[AW+15:16];
                    else         tsy_reg <= prod_reg[AW+15:16];
                end
                hsh_pkg::OP_VI: begin
                    prev_x_reg <= sx_reg;
                    prev_y_reg <= sy_reg;
                end
                hsh_pkg::OP_FIN: begin
                    m_valid_reg <= 1'b1;
                    if (k_reg == hsh_pkg::K_LAST) begin
                        k_reg    <= '0;
                        u_reg    <= '0;
                        urem_reg <= '0;
                    end else begin
                        k_reg <= k_reg + 1'b1;
                        if (urem_sum >= hsh_pkg::U_WRAP) begin
                            urem_reg <= urem_sum - hsh_pkg::U_WRAP;
                            u_reg    <= u_reg + hsh_pkg::U_STEP + 1'b1;
                        end else begin
                            urem_reg <= urem_sum;
                            u_reg    <= u_reg + hsh_pkg::U_STEP;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.load) begin
            head_reg <= s_current_heading;
        end
        case (cmd.op)
            hsh_pkg::OP_SQY, hsh_pkg::OP_M2: begin
                acc_reg <= hsh_pkg::ACC_W'(prod_reg);
            end
            hsh_pkg::OP_SQS, hsh_pkg::OP_M3, hsh_pkg::OP_M4: begin
                acc_reg <= acc_reg + hsh_pkg::ACC_W'(prod_reg);
            end
            hsh_pkg::OP_RTI: begin
                sn_reg   <= {acc_reg[29:0], 16'd0};
                sr_reg   <= '0;
                sbit_reg <= hsh_pkg::SQ_W'(1) << 44;
            end
            hsh_pkg::OP_RT: begin
                if ({1'b0, sn_reg} >= sq_try) begin
                    sn_reg <= sn_reg - sq_try[hsh_pkg::SQ_W-1:0];
                    sr_reg <= (sr_reg >> 1) + sbit_reg;
                end else begin
                    sr_reg <= sr_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            hsh_pkg::OP_CRI: begin
                cx_reg    <= hsh_pkg::CORDIC_GAIN_INV;
                cy_reg    <= '0;
                cz_reg    <= ZW'(ang_q) <<< 16;
                c_neg_reg <= ang_neg;
            end
            hsh_pkg::OP_CR, hsh_pkg::OP_VR: begin
                cx_reg <= x_step;
                cy_reg <= y_step;
                cz_reg <= z_step;
            end
            hsh_pkg::OP_U2: begin
                u2_reg <= prod_reg[32:16];
            end
            hsh_pkg::OP_U3: begin
                u3_reg <= prod_reg[32:16];
            end
            hsh_pkg::OP_PW: begin
                if (cmd.sel) sy_reg <= hsh_pkg::POS_W'($signed(acc_reg[hsh_pkg::ACC_W-1:16]));
                else         sx_reg <= hsh_pkg::POS_W'($signed(acc_reg[hsh_pkg::ACC_W-1:16]));
            end
            hsh_pkg::OP_VI: begin
                zero_vec_reg <= (dx == '0) && (dy == '0);
                if (dx[hsh_pkg::POS_W]) begin
                    cx_reg <= -VW'(dx);
                    cy_reg <= -VW'(dy);
                    cz_reg <= dy[hsh_pkg::POS_W] ? -hsh_pkg::HALF_TURN_Q16
                                                 : hsh_pkg::HALF_TURN_Q16;
                end else begin
                    cx_reg <= VW'(dx);
                    cy_reg <= VW'(dy);
                    cz_reg <= '0;
                end
            end
            hsh_pkg::OP_FIN: begin
                m_dist_reg <= (dq_reg > 24'd255) ? 8'd255 : dq_reg[7:0];
                m_turn_reg <= phi - 10'(head_reg);
                m_last_reg <= (k_reg == hsh_pkg::K_LAST);
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

/* src/hermite_spline_heading_stepper_core.sv */
// Each transaction yields one step; the first step of a path also runs a 23-iteration square
// root and two sine/cosine CORDIC passes of 16 iterations. The shared 16-iteration CORDIC
// and the single multiplier serve one transaction at a time: a new transaction is accepted
// only once the previous one has finished. A stalled result holds the next transaction
// until it is taken.
// Reset: synchronous active-low aresetn clears goal registers, step index and output valid.
`default_nettype none
module hermite_spline_heading_stepper_core (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_addr,
    input  wire logic [14:0]       cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic signed [8:0] s_current_heading,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [7:0]             m_step_distance,
    output logic signed [9:0]      m_turn_angle,
    output logic                   m_last_step
);

    hsh_pkg::cmd_t    cmd;
    hsh_pkg::status_t status;

    hsh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hsh_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_current_heading (s_current_heading),
        .cmd               (cmd),
        .status            (status),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_step_distance   (m_step_distance),
        .m_turn_angle      (m_turn_angle),
        .m_last_step       (m_last_step)
    );

endmodule
`default_nettype wire

/* src/hsh_checker.sv */
// Port-level checks for the stepper core, bound to the top level.
`default_nettype none
module hsh_checker (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_valid,
    input wire logic              s_ready,
    input wire logic              m_valid,
    input wire logic              m_ready,
    input wire logic signed [9:0] m_turn_angle
);

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> (s_ready && !m_valid))
        else $error("not idle after reset");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("transaction accepted while previous one in flight");

    a_result_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result raised without work in progress");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_turn_angle)))
        else $error("stalled result dropped or changed");

endmodule

bind hermite_spline_heading_stepper_core hsh_checker u_hsh_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_turn_angle (m_turn_angle)
);
`default_nettype wire
